// ===== rtl/fccd_pkg.sv =====
`default_nettype none

package fccd_pkg;

  localparam int unsigned SumW     = 28;
  localparam int unsigned RatioW   = 4;
  localparam int unsigned HalvesW  = 6;
  localparam int unsigned WarmW    = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned HistDepth = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_STRONG = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WEAK   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RATIO  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_QUIET  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HALVES = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WARMUP = 3'd5;

  // Register values after reset.
  localparam logic [SumW-1:0]    RST_STRONG = 28'd33000;
  localparam logic [SumW-1:0]    RST_WEAK   = 28'd2500;
  localparam logic [RatioW-1:0]  RST_RATIO  = 4'd5;
  localparam logic [SumW-1:0]    RST_QUIET  = 28'd1000;
  localparam logic [HalvesW-1:0] RST_HALVES = 6'd15;
  localparam logic [WarmW-1:0]   RST_WARMUP = 6'd11;

  // Item kinds.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_GREEN = 2'd1,
    CLS_BROWN = 2'd2,
    CLS_CLEAR = 2'd3
  } cls_e;

  typedef struct packed {
    logic [SumW-1:0]    strong_thr;
    logic [SumW-1:0]    weak_thr;
    logic [RatioW-1:0]  ratio;
    logic [SumW-1:0]    quiet;
    logic [HalvesW-1:0] halves;
    logic [WarmW-1:0]   warmup;
  } cfg_t;

  typedef struct packed {
    logic            action;
    logic [SumW-1:0] green;
    logic [SumW-1:0] brown;
    logic [SumW-1:0] diff;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/fccd_cfg_regs.sv =====
`default_nettype none

module fccd_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fccd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fccd_pkg::SumW-1:0]   cfg_data_i,
  output fccd_pkg::cfg_t                   cfg_o
);
  import fccd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strong_thr <= RST_STRONG;
      cfg_q.weak_thr   <= RST_WEAK;
      cfg_q.ratio      <= RST_RATIO;
      cfg_q.quiet      <= RST_QUIET;
      cfg_q.halves     <= RST_HALVES;
      cfg_q.warmup     <= RST_WARMUP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STRONG: cfg_q.strong_thr <= cfg_data_i;
        REG_WEAK:   cfg_q.weak_thr   <= cfg_data_i;
        REG_RATIO:  cfg_q.ratio      <= cfg_data_i[RatioW-1:0];
        REG_QUIET:  cfg_q.quiet      <= cfg_data_i;
        REG_HALVES: cfg_q.halves     <= cfg_data_i[HalvesW-1:0];
        REG_WARMUP: cfg_q.warmup     <= cfg_data_i[WarmW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/fccd_classify.sv =====
`default_nettype none

module fccd_classify (
  input  fccd_pkg::cfg_t                 cfg_i,
  input  wire logic [fccd_pkg::SumW-1:0] green_i,
  input  wire logic [fccd_pkg::SumW-1:0] brown_i,
  input  wire logic [fccd_pkg::SumW-1:0] diff_i,
  input  wire logic [fccd_pkg::SumW-1:0] baseline_i,
  output fccd_pkg::cls_e                 cls_o
);
  import fccd_pkg::*;

  localparam int unsigned ProdW  = SumW + RatioW;
  localparam int unsigned ClearW = SumW + HalvesW;

  logic [ProdW-1:0]  green_scaled;
  logic [ProdW-1:0]  brown_scaled;
  logic [ClearW-1:0] base_scaled;
  logic [ClearW-1:0] diff_twice;
  logic              green_wins;
  logic              brown_wins;
  logic              is_clear;

  // A color wins on a strong sum that is not outweighed, or on a weak sum
  // that dominates the other color by the configured factor.
  assign green_scaled = ProdW'(cfg_i.ratio) * ProdW'(brown_i);
  assign brown_scaled = ProdW'(cfg_i.ratio) * ProdW'(green_i);

  assign green_wins = ((green_i >= cfg_i.strong_thr) && (green_i >= brown_i)) ||
                      ((green_i >= cfg_i.weak_thr) && (ProdW'(green_i) >= green_scaled));
  assign brown_wins = ((brown_i >= cfg_i.strong_thr) && (brown_i >= green_i)) ||
                      ((brown_i >= cfg_i.weak_thr) && (ProdW'(brown_i) >= brown_scaled));

  // The clear ratio is held in halves, so compare twice the difference sum.
  assign base_scaled = ClearW'(baseline_i) * ClearW'(cfg_i.halves);
  assign diff_twice  = {{(ClearW-SumW-1){1'b0}}, diff_i, 1'b0};
  assign is_clear    = (diff_twice >= base_scaled) &&
                       (green_i <= cfg_i.quiet) && (brown_i <= cfg_i.quiet);

  always_comb begin
    if (green_wins) begin
      cls_o = CLS_GREEN;
    end else if (brown_wins) begin
      cls_o = CLS_BROWN;
    end else if (is_clear) begin
      cls_o = CLS_CLEAR;
    end else begin
      cls_o = CLS_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frame_class_consensus_decider.sv =====
`default_nettype none

// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+-----------------------------------------
// in      | input     | in_valid_i / in_stall_o  | action_i, green_sum_i, brown_sum_i,
//         |           |                          | diff_sum_i
// out     | output    | out_valid_o / out_stall_i| frame_class_o, sort_valid_o, sort_class_o
// cfg     | input     | cfg_we_i (no wait)       | cfg_index_i, cfg_data_i
//
// Each item passes from acceptance through the input register and then through
// the decision logic into the result register.
// One item can be accepted every cycle while the output is not stalled; the rate
// is set by the single pass through the classifier and the state update that closes on itself.
// Reset clears the baseline, the warm-up count, the history and both valid
// flags, and loads the registers with their default values.
// A stall on the output holds the result register and then the input
// register; the input stalls only while its register holds an item.

module frame_class_consensus_decider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         action_i,
  input  wire logic [27:0]                  green_sum_i,
  input  wire logic [27:0]                  brown_sum_i,
  input  wire logic [27:0]                  diff_sum_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        frame_class_o,
  output logic                              sort_valid_o,
  output logic [1:0]                        sort_class_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [fccd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fccd_pkg::SumW-1:0]    cfg_data_i
);
  import fccd_pkg::*;

  cfg_t cfg;

  // Input register.
  logic   in_valid_q;
  frame_t in_q;

  // Decision state.
  logic [SumW-1:0]  base_q, base_d;
  logic [WarmW-1:0] warm_q, warm_d;
  cls_e             hist_q [HistDepth];
  cls_e             hist_d [HistDepth];

  // Result register.
  logic out_valid_q;
  cls_e cls_q, sort_cls_q;
  logic sort_q;

  cls_e frame_cls;
  cls_e cls_d, sort_cls_d;
  logic sort_d;
  logic all_same;
  logic adv;

  fccd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The item in the input register moves on whenever the result register is
  // empty or its result is taken in this cycle.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q.action <= action_i;
      in_q.green  <= green_sum_i;
      in_q.brown  <= brown_sum_i;
      in_q.diff   <= diff_sum_i;
    end
  end

  // The classifier sees the baseline as already raised by this frame.
  fccd_classify u_classify (
    .cfg_i      (cfg),
    .green_i    (in_q.green),
    .brown_i    (in_q.brown),
    .diff_i     (in_q.diff),
    .baseline_i (base_d),
    .cls_o      (frame_cls)
  );

  always_comb begin
    base_d     = base_q;
    warm_d     = warm_q;
    cls_d      = CLS_NONE;
    sort_d     = 1'b0;
    sort_cls_d = CLS_NONE;
    all_same   = 1'b0;
    for (int i = 0; i < HistDepth; i++) begin
      hist_d[i] = hist_q[i];
    end

    if (in_q.action == ACT_START) begin
      // A start item loads the baseline and restarts warm-up and history.
      base_d = in_q.diff;
      warm_d = '0;
      for (int i = 0; i < HistDepth; i++) begin
        hist_d[i] = CLS_NONE;
      end
    end else begin
      if (warm_q < cfg.warmup) begin
        warm_d = warm_q + WarmW'(1);
        if (in_q.diff > base_q) begin
          base_d = in_q.diff;
        end
      end
      cls_d = frame_cls;

      // Shift the new class in at the young end.
      for (int i = 0; i < HistDepth - 1; i++) begin
        hist_d[i] = hist_q[i+1];
      end
      hist_d[HistDepth-1] = frame_cls;

      all_same = (frame_cls != CLS_NONE);
      for (int i = 0; i < HistDepth - 1; i++) begin
        if (hist_d[i] != frame_cls) begin
          all_same = 1'b0;
        end
      end

      // A full run of one class issues a sort command and starts over.
      if (all_same) begin
        sort_d     = 1'b1;
        sort_cls_d = frame_cls;
        for (int i = 0; i < HistDepth; i++) begin
          hist_d[i] = CLS_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      warm_q <= '0;
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= CLS_NONE;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        base_q <= base_d;
        warm_q <= warm_d;
        for (int i = 0; i < HistDepth; i++) begin
          hist_q[i] <= hist_d[i];
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q      <= cls_d;
      sort_q     <= sort_d;
      sort_cls_q <= sort_cls_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_class_o = cls_q;
  assign sort_valid_o  = sort_q;
  assign sort_class_o  = sort_cls_q;

`ifndef SYNTHESIS
  // A sort command always names a real class, and none is named without one.
  a_sort_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sort_valid_o == (sort_class_o != CLS_NONE)))
    else $error("sort class does not match sort flag");

  // A sort command carries the class of the frame that completed the run.
  a_sort_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sort_valid_o) |-> (sort_class_o == frame_class_o))
    else $error("sort class differs from frame class");

  // After a sort command the history starts empty.
  a_hist_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && sort_d) |=> (hist_q[0] == CLS_NONE && hist_q[HistDepth-1] == CLS_NONE))
    else $error("history not cleared after sort");

  // A start item yields an empty result.
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == ACT_START) |=> (frame_class_o == CLS_NONE && !sort_valid_o))
    else $error("start item produced a class");

  // The input only stalls while an item waits in the input register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
